@@ rtl/nsp_pkg.sv @@
// ----------------------------------------------------------------------------
// nsp_pkg
// Types, codes and constants shared by the node solution predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package nsp_pkg;

  localparam int MAX_GEAR_ORDER_DEF = 6;
  localparam int NUM_HIST  = 7;
  localparam int ACC_W     = 100;
  localparam int OPA_W     = 33;
  localparam int OPB_W     = 34;
  localparam int PROD_W    = OPA_W + OPB_W;
  localparam int OUT_DEPTH = 16;

  localparam logic [1:0] METHOD_TRAP = 2'd0;
  localparam logic [1:0] METHOD_GEAR = 2'd1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_ORDER  = 2'd1;
  localparam logic [1:0] ST_BAD_METHOD = 2'd2;

  localparam logic [2:0] REG_METHOD     = 3'd0;
  localparam logic [2:0] REG_ORDER      = 3'd1;
  localparam logic [2:0] REG_STEP_NOW   = 3'd2;
  localparam logic [2:0] REG_STEP_PREV  = 3'd3;
  localparam logic [2:0] REG_STEP_PREV2 = 3'd4;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_PREDICT = 1'b1;

  localparam logic [2:0] ORDER_RESET = 3'd1;
  localparam logic [2:0] COEF_NONE   = 3'd7;

  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic [1:0] status;
    logic       last;
    logic       trap;
  } meta_t;

  typedef struct packed {
    logic                      valid;
    meta_t                     meta;
    logic signed [ACC_W-1:0]   sum;
    prod_t [NUM_HIST-1:0]      prod;
    logic [NUM_HIST-1:0]       shl;
  } stage_t;

  typedef struct packed {
    logic [31:0] prediction;
    logic [1:0]  status;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic        busy;
    logic [63:0] r;
    logic [63:0] ca2;
    logic [63:0] cb2;
  } coef_t;

endpackage

`default_nettype wire

@@ rtl/nsp_if.sv @@
// ----------------------------------------------------------------------------
// nsp_if
// Valid/ready channels of the predictor: items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface nsp_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] hist_0;
  logic signed [31:0] hist_1;
  logic signed [31:0] hist_2;
  logic signed [31:0] hist_3;
  logic signed [31:0] hist_4;
  logic signed [31:0] hist_5;
  logic signed [31:0] hist_6;
  logic        last_node;
  modport source (output valid, kind, coef_index, coef_value, hist_0, hist_1, hist_2,
                  hist_3, hist_4, hist_5, hist_6, last_node, input ready);
  modport sink   (input valid, kind, coef_index, coef_value, hist_0, hist_1, hist_2,
                  hist_3, hist_4, hist_5, hist_6, last_node, output ready);
endinterface

interface nsp_result_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] prediction;
  logic [1:0]  status;
  logic        last_result;
  modport source (output valid, prediction, status, last_result, input ready);
  modport sink   (input valid, prediction, status, last_result, output ready);
endinterface

interface nsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/nsp_coef_seq.sv @@
// ----------------------------------------------------------------------------
// nsp_coef_seq
// Works out the trapezoidal step ratios and their products after each write.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_coef_seq (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        restart,
  input  wire logic [31:0] step_now,
  input  wire logic [31:0] step_prev,
  input  wire logic [31:0] step_prev2,
  output nsp_pkg::coef_t   coef
);
  import nsp_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_DIV  = 4'b0010,
    S_MUL  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t       state;
  logic [5:0]   cnt;
  logic [63:0]  num;
  logic [31:0]  den1, den2, rem1, rem2;
  logic [63:0]  q1, q2;
  logic [127:0] prr, prs;
  logic [63:0]  ca2, cb2;

  logic [32:0]  sh1, sh2;
  logic         ge1, ge2;
  logic [31:0]  ra, rb, sb;
  logic [63:0]  pr, ps;
  logic [1:0]   pos;
  logic [63:0]  qrr, qrs, ca_sum;
  logic         ca_ovf;

  always_comb begin
    sh1 = {rem1, num[63]};
    sh2 = {rem2, num[63]};
    ge1 = sh1 >= {1'b0, den1};
    ge2 = sh2 >= {1'b0, den2};
    ra  = cnt[1] ? q1[63:32] : q1[31:0];
    rb  = cnt[0] ? q1[63:32] : q1[31:0];
    sb  = cnt[0] ? q2[63:32] : q2[31:0];
    pr  = 64'(ra) * 64'(rb);
    ps  = 64'(ra) * 64'(sb);
    pos = 2'(cnt[1]) + 2'(cnt[0]);
    qrr = (prr[127:97] != '0) ? '1 : prr[96:33];
    qrs = (prs[127:97] != '0) ? '1 : prs[96:33];
    {ca_ovf, ca_sum} = {1'b0, q1} + {1'b0, qrr};
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= S_LOAD;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          num   <= {step_now, 32'd0};
          den1  <= (step_prev == '0) ? 32'd1 : step_prev;
          den2  <= (step_prev2 == '0) ? 32'd1 : step_prev2;
          rem1  <= '0;
          rem2  <= '0;
          prr   <= '0;
          prs   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          num  <= {num[62:0], 1'b0};
          rem1 <= ge1 ? 32'(sh1 - {1'b0, den1}) : sh1[31:0];
          rem2 <= ge2 ? 32'(sh2 - {1'b0, den2}) : sh2[31:0];
          q1   <= {q1[62:0], ge1};
          q2   <= {q2[62:0], ge2};
          cnt  <= cnt + 6'd1;
          if (cnt == '1) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prr <= prr + ({64'd0, pr} << {pos, 5'd0});
          prs <= prs + ({64'd0, ps} << {pos, 5'd0});
          cnt <= cnt + 6'd1;
          if (cnt[1:0] == 2'd3) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // Final products are folded in here once the sums have settled.
          ca2 <= ca_ovf ? '1 : ca_sum;
          cb2 <= qrs;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // The coefficients are flagged ready in the cycle after the sequencer reaches its last state.
  logic done_d;
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      done_d <= 1'b0;
    end else begin
      done_d <= (state == S_DONE);
    end
  end

  assign coef.busy = !done_d;
  assign coef.r    = q1;
  assign coef.ca2  = ca2;
  assign coef.cb2  = cb2;

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == '1 && !restart) |=> state == S_MUL)
    else $error("divider did not finish after the full quotient");
  a_busy_seq: assert property (@(posedge clk) disable iff (rst)
    (state != S_DONE) |-> coef.busy)
    else $error("coefficients flagged ready while still being worked out");
  a_restart: assert property (@(posedge clk) disable iff (rst)
    restart |=> state == S_LOAD && coef.busy)
    else $error("register write did not restart the sequencer");

endmodule

`default_nettype wire

@@ rtl/nsp_cell.sv @@
// ----------------------------------------------------------------------------
// nsp_cell
// One link of the accumulation chain: adds the front product lane to the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_cell (
  input  wire logic     clk,
  input  wire logic     rst,
  input  nsp_pkg::stage_t din,
  output nsp_pkg::stage_t dout
);
  import nsp_pkg::*;

  logic signed [ACC_W-1:0] term;

  always_comb begin
    term = ACC_W'(din.prod[0]);
    if (din.shl[0]) begin
      term = term <<< 32;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.meta <= din.meta;
    dout.sum  <= din.sum + term;
    dout.prod <= {prod_t'(0), din.prod[NUM_HIST-1:1]};
    dout.shl  <= {1'b0, din.shl[NUM_HIST-1:1]};
  end

endmodule

`default_nettype wire

@@ rtl/nsp_fifo.sv @@
// ----------------------------------------------------------------------------
// nsp_fifo
// Result queue that absorbs the pipeline while the result side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_fifo #(
  parameter int DEPTH = nsp_pkg::OUT_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  nsp_pkg::result_t wdata,
  input  wire logic       pop,
  output nsp_pkg::result_t rdata,
  output logic            not_empty
);
  import nsp_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  result_t        mem [DEPTH];
  logic [PW-1:0]  wr, rd;
  logic [CW-1:0]  count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr <= (wr == PW'(DEPTH - 1)) ? '0 : wr + PW'(1);
      end
      if (pop) begin
        rd <= (rd == PW'(DEPTH - 1)) ? '0 : rd + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  assign rdata     = mem[rd];
  assign not_empty = (count != '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != CW'(DEPTH) || pop))
    else $error("result queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("result queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + CW'(1))
    else $error("queue fill count lost a beat");

endmodule

`default_nettype wire

@@ rtl/node_solution_predictor.sv @@
// ----------------------------------------------------------------------------
// node_solution_predictor
// Polynomial extrapolation of circuit node solutions, trapezoidal and Gear.
// ----------------------------------------------------------------------------
// One predict beat is taken per clock while the step ratios are ready and the
// result queue has credit; its result passes the entry multiply stage, seven
// accumulating cells and the rounding logic; load beats finish on acceptance and
// give no result. A 16-deep result queue with a credit count lets items keep
// flowing while the result side stalls. After reset and after every register
// write the step ratios are recomputed by bit-serial dividers and a 32x32
// multiplier; no item is accepted in that time, register writes still are.
`default_nettype none

module node_solution_predictor #(
  parameter int MAX_GEAR_ORDER = nsp_pkg::MAX_GEAR_ORDER_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  nsp_item_if.sink     item,
  nsp_result_if.source result,
  nsp_cfg_if.sink      cfg
);
  import nsp_pkg::*;

  localparam int CW = $clog2(OUT_DEPTH + 1);

  logic [1:0]  method;
  logic [2:0]  order;
  logic [31:0] step_now, step_prev, step_prev2;
  logic signed [31:0] gcoef [NUM_HIST];

  coef_t       coef;
  logic        cfg_wr, acc_in, acc_pred, pop;
  logic [CW-1:0] credit;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      method     <= METHOD_TRAP;
      order      <= ORDER_RESET;
      step_now   <= 32'd1;
      step_prev  <= 32'd1;
      step_prev2 <= 32'd1;
    end else if (cfg_wr) begin
      unique case (cfg.index)
        REG_METHOD:     method     <= cfg.data[1:0];
        REG_ORDER:      order      <= cfg.data[2:0];
        REG_STEP_NOW:   step_now   <= cfg.data;
        REG_STEP_PREV:  step_prev  <= cfg.data;
        REG_STEP_PREV2: step_prev2 <= cfg.data;
        default: ;
      endcase
    end
  end

  nsp_coef_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .restart    (cfg_wr),
    .step_now   (step_now),
    .step_prev  (step_prev),
    .step_prev2 (step_prev2),
    .coef       (coef)
  );

  assign item.ready = !coef.busy && (credit < CW'(OUT_DEPTH));
  assign acc_in     = item.valid && item.ready;
  assign acc_pred   = acc_in && (item.kind == KIND_PREDICT);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_HIST; k++) begin
        gcoef[k] <= '0;
      end
    end else if (acc_in && item.kind == KIND_LOAD) begin
      for (int k = 0; k < NUM_HIST; k++) begin
        if (item.coef_index == 3'(k)) begin
          gcoef[k] <= item.coef_value;
        end
      end
    end
  end

  // Entry stage: operand selection and one product per lane.
  logic signed [31:0]      h [NUM_HIST];
  logic signed [OPA_W-1:0] opa [NUM_HIST];
  logic signed [OPB_W-1:0] opb [NUM_HIST];
  logic [NUM_HIST-1:0]     shl;
  logic signed [OPB_W-1:0] d01, nd12;
  logic [63:0]             ca, cb;
  logic [1:0]              status;
  stage_t                  s0;
  stage_t                  chain [NUM_HIST+1];

  always_comb begin
    h[0] = item.hist_0; h[1] = item.hist_1; h[2] = item.hist_2; h[3] = item.hist_3;
    h[4] = item.hist_4; h[5] = item.hist_5; h[6] = item.hist_6;
    d01  = OPB_W'(h[0]) - OPB_W'(h[1]);
    nd12 = OPB_W'(h[2]) - OPB_W'(h[1]);
    ca   = (order == 3'd2) ? coef.ca2 : coef.r;
    cb   = (order == 3'd2) ? coef.cb2 : 64'd0;
    priority if (method == METHOD_TRAP) begin
      status = (order == 3'd1 || order == 3'd2) ? ST_OK : ST_BAD_ORDER;
    end else if (method == METHOD_GEAR) begin
      status = (order >= 3'd1 && 32'(order) <= 32'(MAX_GEAR_ORDER)) ? ST_OK : ST_BAD_ORDER;
    end else begin
      status = ST_BAD_METHOD;
    end
    for (int k = 0; k < NUM_HIST; k++) begin
      opa[k] = '0;
      opb[k] = '0;
      shl[k] = 1'b0;
    end
    if (status == ST_OK && method == METHOD_TRAP) begin
      opa[0] = OPA_W'(h[0]);           opb[0] = OPB_W'(1); shl[0] = 1'b1;
      opa[1] = {1'b0, ca[31:0]};        opb[1] = d01;
      opa[2] = {1'b0, ca[63:32]};       opb[2] = d01;       shl[2] = 1'b1;
      opa[3] = {1'b0, cb[31:0]};        opb[3] = nd12;
      opa[4] = {1'b0, cb[63:32]};       opb[4] = nd12;      shl[4] = 1'b1;
    end else if (status == ST_OK) begin
      for (int k = 0; k < NUM_HIST; k++) begin
        if (3'(k) <= order) begin
          opa[k] = OPA_W'(gcoef[k]);
          opb[k] = OPB_W'(h[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
    end else begin
      s0.valid <= acc_pred;
    end
    s0.meta.status <= status;
    s0.meta.last   <= item.last_node;
    s0.meta.trap   <= (method == METHOD_TRAP);
    s0.sum         <= '0;
    s0.shl         <= shl;
    for (int k = 0; k < NUM_HIST; k++) begin
      s0.prod[k] <= PROD_W'(opa[k]) * PROD_W'(opb[k]);
    end
  end

  assign chain[0] = s0;

  for (genvar g = 0; g < NUM_HIST; g++) begin : g_cell
    nsp_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  // Round half up, shift to Q16.16, saturate.
  stage_t                  tail;
  logic signed [ACC_W-1:0] rsum, rsh;
  result_t                 res;

  always_comb begin
    tail = chain[NUM_HIST];
    rsum = tail.sum + (tail.meta.trap ? (ACC_W'(1) <<< 31) : (ACC_W'(1) <<< 23));
    rsh  = tail.meta.trap ? (rsum >>> 32) : (rsum >>> 24);
    if ((&rsh[ACC_W-1:31]) || !(|rsh[ACC_W-1:31])) begin
      res.prediction = rsh[31:0];
    end else begin
      res.prediction = rsh[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    if (tail.meta.status != ST_OK) begin
      res.prediction = '0;
    end
    res.status      = tail.meta.status;
    res.last_result = tail.meta.last;
  end

  result_t rq;
  logic    rq_valid;

  nsp_fifo #(.DEPTH(OUT_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (tail.valid),
    .wdata     (res),
    .pop       (pop),
    .rdata     (rq),
    .not_empty (rq_valid)
  );

  assign pop                = rq_valid && result.ready;
  assign result.valid       = rq_valid;
  assign result.prediction  = rq.prediction;
  assign result.status      = rq.status;
  assign result.last_result = rq.last_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + CW'(acc_pred) - CW'(pop);
    end
  end

  a_credit_max: assert property (@(posedge clk) disable iff (rst)
    credit <= CW'(OUT_DEPTH))
    else $error("more items in flight than the result queue holds");
  a_tail_credit: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> credit != '0)
    else $error("result produced with no item outstanding");
  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    coef.busy |-> !acc_in)
    else $error("item taken while step ratios were being recomputed");

endmodule

`default_nettype wire
